>>> design/hcf_pkg.sv
// Shared types, codes and constants of the HTTP chunk framer.
package hcf_pkg;

    localparam int DEF_BUFFER_DEPTH = 4096;
    localparam int PAY_W            = 13;
    localparam int SLOT_W           = 16;

    localparam logic [SLOT_W-1:0] MIN_SLOT  = 16'd5;
    localparam logic [SLOT_W-1:0] SLOT_PRE4 = 16'd21;
    localparam logic [SLOT_W-1:0] SLOT_PRE5 = 16'd262;
    localparam logic [SLOT_W-1:0] SLOT_PRE6 = 16'd4103;
    localparam logic [SLOT_W-1:0] CAP_1DIG  = 16'h000f;
    localparam logic [SLOT_W-1:0] CAP_2DIG  = 16'h00ff;
    localparam logic [SLOT_W-1:0] CAP_3DIG  = 16'h0fff;
    localparam logic [SLOT_W-1:0] CAP_4DIG  = 16'hffff;

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_OPEN = 2'd1,
        KIND_PULL = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_CHUNK   = 2'd1,
        ST_TRAILER = 2'd2,
        ST_DONE    = 2'd3
    } t_stage;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_SMALL     = 3'd2,
        STAT_NOT_READY = 3'd3,
        STAT_FINISHED  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             from_mem;
        logic             out_valid;
        logic             last;
        logic [PAY_W-1:0] chunk_payload;
        t_status          status;
    } t_res;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'd0, nib};
        end else begin
            ch = 8'h57 + {4'd0, nib};
        end
        return ch;
    endfunction

endpackage

>>> design/hcf_if.sv
// Valid/ready channel interfaces of the HTTP chunk framer.
interface hcf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] slot_len;

    modport source (output valid, kind, data_byte, slot_len, input ready);
    modport sink   (input valid, kind, data_byte, slot_len, output ready);
endinterface

interface hcf_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic        last;
    logic [12:0] chunk_payload;
    logic [2:0]  status;

    modport source (output valid, out_byte, out_valid, last, chunk_payload, status,
                    input ready);
    modport sink   (input valid, out_byte, out_valid, last, chunk_payload, status,
                    output ready);
endinterface

>>> design/http_chunk_framer_unit.sv
// HTTP chunk framer: payload ring, chunk sizing and byte-wise chunk emission.
//
// Usage: one request per transfer on i_in (kind = push, open or pull), one
// result per request on o_out, in request order. Pushes store a byte in the
// payload ring; an open sizes a chunk for the offered slot (or starts the
// "0 CR LF CR LF" trailer when the ring is empty); each pull returns one
// framed byte: hex length, CR LF, payload, CR LF.
// A result passes the memory output stage, then the output register, before o_out.
// Throughput: one request per cycle unless back-pressured; the ring memory is read
// once per cycle for payload bytes and written once per cycle for pushes, never both.
// The result path holds two entries (memory output stage, output register),
// so a request is still taken while one finished result waits on o_out.
// Back-pressure: with both entries held and o_out.ready low, i_in.ready
// drops until the output is taken; nothing is lost or repeated.
// Reset: pointers, fill count, emission state and both result entries are
// cleared; prefix length returns to three. Ring contents are not cleared and
// need no clearing pass, as only written entries are ever read.
module http_chunk_framer_unit #(
    parameter int BUFFER_DEPTH = hcf_pkg::DEF_BUFFER_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    hcf_in_if.sink       i_in,
    hcf_out_if.source    o_out
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int PAY_W = hcf_pkg::PAY_W;

    logic [7:0]       r_store [BUFFER_DEPTH];
    logic [7:0]       r_mem_q;

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    hcf_pkg::t_stage  r_stage, n_stage;
    logic [PAY_W-1:0] r_emit, n_emit;
    logic [PAY_W-1:0] r_chunk_len, n_chunk_len;
    logic [2:0]       r_pre, n_pre;

    hcf_pkg::t_res    r_p, n_p;
    logic             r_p_v;
    hcf_pkg::t_res    r_o;
    logic             r_o_v;

    logic             accept;
    logic             p_move;
    logic             wr_en;
    logic             rd_en;
    logic             full;

    // sizing
    logic [15:0]      cnt16;
    logic [15:0]      room;
    logic [15:0]      used16;
    logic [15:0]      cap16;
    logic [2:0]       pre;
    logic [PAY_W-1:0] used;

    // chunk emission position decode
    logic [PAY_W-1:0] digits;
    logic [PAY_W-1:0] body_end;
    logic [PAY_W-1:0] nib_sel;
    logic [15:0]      len16;
    logic [3:0]       nib;
    logic             is_digit, is_cr1, is_lf1, is_body, is_cr2;
    logic [2:0]       trl_pos;
    logic [7:0]       trl_byte;

    assign p_move     = r_p_v && (!r_o_v || o_out.ready);
    assign i_in.ready = !r_p_v || p_move;
    assign accept     = i_in.valid && i_in.ready;
    assign full       = (r_count >= CNT_W'(BUFFER_DEPTH));

    always_comb begin
        cnt16 = 16'(r_count);
        pre   = 3'd3;
        if (i_in.slot_len > hcf_pkg::SLOT_PRE4 && cnt16 > hcf_pkg::CAP_1DIG) begin
            pre = 3'd4;
            if (i_in.slot_len > hcf_pkg::SLOT_PRE5 && cnt16 > hcf_pkg::CAP_2DIG) begin
                pre = 3'd5;
                if (i_in.slot_len > hcf_pkg::SLOT_PRE6 && cnt16 > hcf_pkg::CAP_3DIG) begin
                    pre = 3'd6;
                end
            end
        end
        room   = i_in.slot_len - 16'(pre) - 16'd2;
        used16 = (cnt16 < room) ? cnt16 : room;
        case (pre)
            3'd3:    cap16 = hcf_pkg::CAP_1DIG;
            3'd4:    cap16 = hcf_pkg::CAP_2DIG;
            3'd5:    cap16 = hcf_pkg::CAP_3DIG;
            default: cap16 = hcf_pkg::CAP_4DIG;
        endcase
        if (used16 > cap16) begin
            used16 = cap16;
        end
        used = used16[PAY_W-1:0];
    end

    always_comb begin
        digits   = PAY_W'(r_pre) - PAY_W'(2);
        body_end = PAY_W'(r_pre) + r_chunk_len;
        nib_sel  = digits - PAY_W'(1) - r_emit;
        len16    = 16'(r_chunk_len);
        case (nib_sel[1:0])
            2'd0:    nib = len16[3:0];
            2'd1:    nib = len16[7:4];
            2'd2:    nib = len16[11:8];
            default: nib = len16[15:12];
        endcase
        is_digit = (r_emit < digits);
        is_cr1   = (r_emit == digits);
        is_lf1   = (r_emit == digits + PAY_W'(1));
        is_body  = !is_digit && !is_cr1 && !is_lf1 && (r_emit < body_end);
        is_cr2   = (r_emit == body_end);
        trl_pos  = (r_emit < PAY_W'(5)) ? r_emit[2:0] : 3'd4;
        case (trl_pos)
            3'd0:    trl_byte = hcf_pkg::CH_ZERO;
            3'd1:    trl_byte = hcf_pkg::CH_CR;
            3'd2:    trl_byte = hcf_pkg::CH_LF;
            3'd3:    trl_byte = hcf_pkg::CH_CR;
            default: trl_byte = hcf_pkg::CH_LF;
        endcase
    end

    assign wr_en = accept && (i_in.kind == hcf_pkg::KIND_PUSH)
                   && (r_stage != hcf_pkg::ST_DONE) && !full;
    assign rd_en = accept && (i_in.kind == hcf_pkg::KIND_PULL)
                   && (r_stage == hcf_pkg::ST_CHUNK) && is_body;

    // next state
    always_comb begin
        n_rd_ptr    = r_rd_ptr;
        n_wr_ptr    = r_wr_ptr;
        n_count     = r_count;
        n_stage     = r_stage;
        n_emit      = r_emit;
        n_chunk_len = r_chunk_len;
        n_pre       = r_pre;
        if (accept) begin
            case (i_in.kind)
                hcf_pkg::KIND_PUSH: begin
                    if (wr_en) begin
                        n_wr_ptr = (r_wr_ptr == PTR_W'(BUFFER_DEPTH - 1)) ?
                                   '0 : r_wr_ptr + PTR_W'(1);
                        n_count  = r_count + CNT_W'(1);
                    end
                end
                hcf_pkg::KIND_OPEN: begin
                    if (r_stage == hcf_pkg::ST_IDLE) begin
                        if (r_count == '0) begin
                            n_stage = hcf_pkg::ST_TRAILER;
                            n_emit  = '0;
                        end else if (i_in.slot_len > hcf_pkg::MIN_SLOT) begin
                            n_pre       = pre;
                            n_chunk_len = used;
                            n_emit      = '0;
                            n_stage     = hcf_pkg::ST_CHUNK;
                        end
                    end
                end
                hcf_pkg::KIND_PULL: begin
                    unique case (r_stage)
                        hcf_pkg::ST_TRAILER: begin
                            if (trl_pos == 3'd4) begin
                                n_stage = hcf_pkg::ST_DONE;
                                n_emit  = '0;
                            end else begin
                                n_emit = PAY_W'(trl_pos) + PAY_W'(1);
                            end
                        end
                        hcf_pkg::ST_CHUNK: begin
                            if (is_body) begin
                                n_rd_ptr = (r_rd_ptr == PTR_W'(BUFFER_DEPTH - 1)) ?
                                           '0 : r_rd_ptr + PTR_W'(1);
                                if (r_count != '0) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                            if (!is_digit && !is_cr1 && !is_lf1 && !is_body && !is_cr2) begin
                                n_stage = hcf_pkg::ST_IDLE;
                                n_emit  = '0;
                            end else begin
                                n_emit = r_emit + PAY_W'(1);
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // result of the current request
    always_comb begin
        n_p = '{out_byte: 8'd0, from_mem: 1'b0, out_valid: 1'b0, last: 1'b0,
                chunk_payload: '0, status: hcf_pkg::STAT_OK};
        case (i_in.kind)
            hcf_pkg::KIND_PUSH: begin
                if (r_stage == hcf_pkg::ST_DONE) begin
                    n_p.status = hcf_pkg::STAT_FINISHED;
                end else if (full) begin
                    n_p.status = hcf_pkg::STAT_FULL;
                end
            end
            hcf_pkg::KIND_OPEN: begin
                if (r_stage == hcf_pkg::ST_DONE) begin
                    n_p.status = hcf_pkg::STAT_FINISHED;
                end else if (r_stage != hcf_pkg::ST_IDLE) begin
                    n_p.status = hcf_pkg::STAT_NOT_READY;
                end else if (r_count != '0) begin
                    if (i_in.slot_len <= hcf_pkg::MIN_SLOT) begin
                        n_p.status = hcf_pkg::STAT_SMALL;
                    end else begin
                        n_p.chunk_payload = used;
                    end
                end
            end
            hcf_pkg::KIND_PULL: begin
                unique case (r_stage)
                    hcf_pkg::ST_DONE: n_p.status = hcf_pkg::STAT_FINISHED;
                    hcf_pkg::ST_IDLE: n_p.status = hcf_pkg::STAT_NOT_READY;
                    hcf_pkg::ST_TRAILER: begin
                        n_p.out_valid = 1'b1;
                        n_p.out_byte  = trl_byte;
                        n_p.last      = (trl_pos == 3'd4);
                    end
                    default: begin
                        n_p.out_valid = 1'b1;
                        if (is_digit) begin
                            n_p.out_byte = hcf_pkg::hex_char(nib);
                        end else if (is_cr1) begin
                            n_p.out_byte = hcf_pkg::CH_CR;
                        end else if (is_lf1) begin
                            n_p.out_byte = hcf_pkg::CH_LF;
                        end else if (is_body) begin
                            n_p.from_mem = 1'b1;
                        end else if (is_cr2) begin
                            n_p.out_byte = hcf_pkg::CH_CR;
                        end else begin
                            n_p.out_byte = hcf_pkg::CH_LF;
                            n_p.last     = 1'b1;
                        end
                    end
                endcase
            end
            default: n_p.status = hcf_pkg::STAT_NOT_READY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[r_wr_ptr] <= i_in.data_byte;
        end
        if (rd_en) begin
            r_mem_q <= r_store[r_rd_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p <= n_p;
        end
        if (p_move) begin
            r_o <= '{out_byte: (r_p.from_mem ? r_mem_q : r_p.out_byte),
                     from_mem: r_p.from_mem, out_valid: r_p.out_valid, last: r_p.last,
                     chunk_payload: r_p.chunk_payload, status: r_p.status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_stage     <= hcf_pkg::ST_IDLE;
            r_emit      <= '0;
            r_chunk_len <= '0;
            r_pre       <= 3'd3;
            r_p_v       <= 1'b0;
            r_o_v       <= 1'b0;
        end else begin
            r_rd_ptr    <= n_rd_ptr;
            r_wr_ptr    <= n_wr_ptr;
            r_count     <= n_count;
            r_stage     <= n_stage;
            r_emit      <= n_emit;
            r_chunk_len <= n_chunk_len;
            r_pre       <= n_pre;
            if (accept) begin
                r_p_v <= 1'b1;
            end else if (p_move) begin
                r_p_v <= 1'b0;
            end
            if (p_move) begin
                r_o_v <= 1'b1;
            end else if (o_out.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    assign o_out.valid         = r_o_v;
    assign o_out.out_byte      = r_o.out_byte;
    assign o_out.out_valid     = r_o.out_valid;
    assign o_out.last          = r_o.last;
    assign o_out.chunk_payload = r_o.chunk_payload;
    assign o_out.status        = r_o.status;

endmodule
